// ----- rtl/jsu_pkg.sv -----
`default_nettype none

package jsu_pkg;

  // Result kinds carried on the kind field.
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Characters the decoder looks for.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  // Control characters produced by the one-letter escapes.
  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_FF = 8'h0C;
  localparam logic [7:0] CTL_LF = 8'h0A;
  localparam logic [7:0] CTL_CR = 8'h0D;
  localparam logic [7:0] CTL_HT = 8'h09;

  // One decoded result as it leaves the block.
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;
  } result_t;

  // True for 0-9, a-f and A-F.
  function automatic logic is_hex_digit(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

endpackage

`default_nettype wire

// ----- rtl/jsu_if.sv -----
`default_nettype none

// Raw string bytes going into the decoder.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// Decoded results coming out of the decoder.
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last;

  modport source (output valid, output out_byte, output kind, output last, input ready);
  modport sink (input valid, input out_byte, input kind, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/jsu_core.sv -----
`default_nettype none

module jsu_core
  import jsu_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic    can_load,
  output logic         load,
  output result_t      result
);

  typedef enum logic [2:0] {
    PH_NORMAL,
    PH_ESCAPE,
    PH_HEX0,
    PH_HEX1,
    PH_HEX2,
    PH_HEX3
  } phase_t;

  phase_t     phase;
  phase_t     phase_next;
  logic       a_valid;
  logic [7:0] a_byte;
  logic       second;

  logic [1:0] cnt;
  result_t    r0;
  result_t    r1;
  logic       consume;

  // Decode the held byte against the current escape phase.
  always_comb begin
    cnt        = 2'd1;
    r0         = '{out_byte: a_byte, kind: KIND_DATA, last: 1'b1};
    r1         = '{out_byte: CH_U, kind: KIND_DATA, last: 1'b1};
    phase_next = PH_NORMAL;
    unique case (phase)
      PH_ESCAPE: begin
        case (a_byte)
          CH_QUOTE:  r0.out_byte = CH_QUOTE;
          CH_BSLASH: r0.out_byte = CH_BSLASH;
          CH_SLASH:  r0.out_byte = CH_SLASH;
          CH_B:      r0.out_byte = CTL_BS;
          CH_F:      r0.out_byte = CTL_FF;
          CH_N:      r0.out_byte = CTL_LF;
          CH_R:      r0.out_byte = CTL_CR;
          CH_T:      r0.out_byte = CTL_HT;
          CH_U: begin
            cnt        = 2'd2;
            r0         = '{out_byte: CH_BSLASH, kind: KIND_DATA, last: 1'b0};
            phase_next = PH_HEX0;
          end
          default:   r0.out_byte = CH_BSLASH;
        endcase
      end
      PH_HEX0, PH_HEX1, PH_HEX2, PH_HEX3: begin
        if (!is_hex_digit(a_byte)) begin
          r0 = '{out_byte: 8'h00, kind: KIND_ERROR, last: 1'b1};
        end else begin
          unique case (phase)
            PH_HEX0: phase_next = PH_HEX1;
            PH_HEX1: phase_next = PH_HEX2;
            PH_HEX2: phase_next = PH_HEX3;
            default: phase_next = PH_NORMAL;
          endcase
        end
      end
      default: begin
        // Normal text, and any unused phase code behaves the same way.
        if (a_byte == CH_QUOTE) begin
          r0 = '{out_byte: 8'h00, kind: KIND_END, last: 1'b1};
        end else if (a_byte == CH_BSLASH) begin
          cnt        = 2'd0;
          phase_next = PH_ESCAPE;
        end
      end
    endcase
  end

  // Hand one result per cycle to the output register while it can take one; a
  // two-result byte stays in the input register until its second result is loaded.
  always_comb begin
    result   = second ? r1 : r0;
    load     = a_valid && (cnt != 2'd0) && can_load;
    consume  = a_valid && ((cnt == 2'd0) ||
               (can_load && ((cnt == 2'd1) || second)));
    in_ready = !a_valid || consume;
  end

  // Input register, escape phase and second-result flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      second  <= 1'b0;
      phase   <= PH_NORMAL;
    end else begin
      if (in_valid && in_ready) begin
        a_valid <= 1'b1;
      end else if (consume) begin
        a_valid <= 1'b0;
      end
      if (consume) begin
        second <= 1'b0;
        phase  <= phase_next;
      end else if (load && (cnt == 2'd2)) begin
        second <= 1'b1;
      end
    end
  end

  // Byte holding register.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_byte <= in_byte;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/jsu_out_stage.sv -----
`default_nettype none

module jsu_out_stage
  import jsu_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t result,
  output logic         can_load,
  jsu_out_if.source    out_ch
);

  logic    o_valid;
  result_t o_data;

  // The register may take a new result when empty or being drained.
  assign can_load = !o_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (load) begin
      o_valid <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_data <= result;
    end
  end

  assign out_ch.valid    = o_valid;
  assign out_ch.out_byte = o_data.out_byte;
  assign out_ch.kind     = o_data.kind;
  assign out_ch.last     = o_data.last;

endmodule

`default_nettype wire

// ----- rtl/json_string_unescape.sv -----
// Channel   Role   Payload
// in_ch     sink   in_byte[7:0]
// out_ch    source out_byte[7:0], kind[1:0], last
//
// One input byte per cycle while out_ch is not stalled; a \u escape gives two
// results, so its 'u' byte stays in the input register until both are loaded.
// A byte passes through the input register, decode and the result register.
// rst is synchronous and returns the decoder to plain text with both
// registers empty. A stall on out_ch fills the result register, then the
// input register, and then drops in_ch.ready.
`default_nettype none

module json_string_unescape
  import jsu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  jsu_in_if.sink    in_ch,
  jsu_out_if.source out_ch
);

  logic    can_load;
  logic    load;
  result_t result;

  // Escape decoding and input holding register.
  jsu_core u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_byte  (in_ch.in_byte),
    .can_load (can_load),
    .load     (load),
    .result   (result)
  );

  // Result register toward the consumer.
  jsu_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .result   (result),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

// ----- rtl/jsu_check.sv -----
`default_nettype none

module jsu_check
  import jsu_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic [1:0] kind,
  input wire logic       last
);

  // A stalled result beat holds its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(kind) && $stable(last))
    else $error("stalled result changed");

  // Only the three defined kinds appear.
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind != 2'd3)
    else $error("undefined result kind");

  // End and error beats carry a zero byte.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_DATA |-> out_byte == 8'h00 && last)
    else $error("end or error beat with data");

  // The only non-final result is the backslash that opens a \u escape.
  a_first: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> kind == KIND_DATA && out_byte == CH_BSLASH)
    else $error("unexpected non-final result");

  // Its partner 'u' follows right after it is taken.
  a_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid && last &&
      kind == KIND_DATA && out_byte == CH_U)
    else $error("missing u after escape backslash");

endmodule

bind json_string_unescape jsu_check u_check (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .kind      (out_ch.kind),
  .last      (out_ch.last)
);

`default_nettype wire
